[sv/tbw_pkg.sv]
// ----------------------------------------------------------------------------
// tbw_pkg: shared constants and types of the barycentric weights unit
// Fixed widths of the result fields, saturation codes and queue status.
// ----------------------------------------------------------------------------
package tbw_pkg;

	// Result weights are signed fixed point in a 32-bit word.
	localparam int WEIGHT_W = 32;

	// A quotient that is not saturated fits in this many magnitude bits.
	localparam int QUOT_BITS = WEIGHT_W - 1;

	localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
	localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};
	localparam logic signed [WEIGHT_W-1:0] WEIGHT_ZERO = '0;

	// Queue between the front and back parts.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic full;
		logic empty;
	} tbw_qstat_t;

endpackage

[sv/tbw_if.sv]
// ----------------------------------------------------------------------------
// tbw_if: valid/ready channels of the barycentric weights unit
// One interface for the query beats and one for the weight beats.
// ----------------------------------------------------------------------------
interface tbw_in_if #(
	parameter int COORD_BITS = 16
);
	logic valid;
	logic ready;
	logic [COORD_BITS-1:0] query_x;
	logic [COORD_BITS-1:0] query_y;
	logic [COORD_BITS-1:0] query_z;
	logic [COORD_BITS-1:0] vert_a_x;
	logic [COORD_BITS-1:0] vert_a_y;
	logic [COORD_BITS-1:0] vert_a_z;
	logic [COORD_BITS-1:0] vert_b_x;
	logic [COORD_BITS-1:0] vert_b_y;
	logic [COORD_BITS-1:0] vert_b_z;
	logic [COORD_BITS-1:0] vert_c_x;
	logic [COORD_BITS-1:0] vert_c_y;
	logic [COORD_BITS-1:0] vert_c_z;

	modport source (
		output valid, query_x, query_y, query_z, vert_a_x, vert_a_y, vert_a_z,
			vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
		input ready
	);
	modport sink (
		input valid, query_x, query_y, query_z, vert_a_x, vert_a_y, vert_a_z,
			vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
		output ready
	);
endinterface

interface tbw_out_if;
	logic valid;
	logic ready;
	logic signed [tbw_pkg::WEIGHT_W-1:0] weight_a;
	logic signed [tbw_pkg::WEIGHT_W-1:0] weight_b;
	logic signed [tbw_pkg::WEIGHT_W-1:0] weight_c;
	logic degenerate;

	modport source (
		output valid, weight_a, weight_b, weight_c, degenerate,
		input ready
	);
	modport sink (
		input valid, weight_a, weight_b, weight_c, degenerate,
		output ready
	);
endinterface

[sv/tbw_front.sv]
// ----------------------------------------------------------------------------
// tbw_front: dot products, Gram determinant and weight numerators
// Seven-stage pipeline that accepts query beats and pushes exact numerators.
// ----------------------------------------------------------------------------
module tbw_front #(
	parameter int COORD_BITS = 16,
	parameter int NW = 2 * (2 * (COORD_BITS + 1) + 2) + 3
) (
	input  logic clk,
	input  logic arst_n,
	tbw_in_if.sink query,
	input  tbw_pkg::tbw_qstat_t qstat,
	output logic push,
	output logic [4*NW:0] push_data
);
	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;
	localparam int SW = PW + 2;
	localparam int HB = SW / 2;
	localparam int PPW = SW + 1;
	localparam int GW = 2 * SW;
	localparam int NPROD = 6;
	localparam int PA [NPROD] = '{0, 1, 2, 1, 0, 1};
	localparam int PB [NPROD] = '{2, 1, 3, 4, 4, 3};

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic signed [DW-1:0] e0_s1 [3];
	logic signed [DW-1:0] e1_s1 [3];
	logic signed [DW-1:0] p_s1 [3];
	logic signed [PW-1:0] prod_s2 [5][3];
	logic signed [SW-1:0] dot_s3 [5];
	logic signed [PPW-1:0] hh_s4 [NPROD];
	logic signed [PPW-1:0] hl_s4 [NPROD];
	logic signed [PPW-1:0] lh_s4 [NPROD];
	logic signed [PPW-1:0] ll_s4 [NPROD];
	logic signed [GW-1:0] t_s5 [NPROD];
	logic signed [NW-1:0] den_s6, nb_s6, nc_s6;
	logic signed [NW-1:0] den_s7, na_s7, nb_s7, nc_s7;
	logic deg_s7;

	logic signed [DW-1:0] qv [3];
	logic signed [DW-1:0] av [3];
	logic signed [DW-1:0] bv [3];
	logic signed [DW-1:0] cv [3];

	assign en = !v_s7 || !qstat.full;
	assign query.ready = en;
	assign push = v_s7 && !qstat.full;
	assign push_data = {deg_s7, den_s7, na_s7, nb_s7, nc_s7};

	always_comb begin
		qv[0] = DW'($signed(query.query_x));
		qv[1] = DW'($signed(query.query_y));
		qv[2] = DW'($signed(query.query_z));
		av[0] = DW'($signed(query.vert_a_x));
		av[1] = DW'($signed(query.vert_a_y));
		av[2] = DW'($signed(query.vert_a_z));
		bv[0] = DW'($signed(query.vert_b_x));
		bv[1] = DW'($signed(query.vert_b_y));
		bv[2] = DW'($signed(query.vert_b_z));
		cv[0] = DW'($signed(query.vert_c_x));
		cv[1] = DW'($signed(query.vert_c_y));
		cv[2] = DW'($signed(query.vert_c_z));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= query.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Edge vectors and offset from the first vertex.
			for (int k = 0; k < 3; k++) begin
				e0_s1[k] <= bv[k] - av[k];
				e1_s1[k] <= cv[k] - av[k];
				p_s1[k] <= qv[k] - av[k];
			end
			for (int k = 0; k < 3; k++) begin
				prod_s2[0][k] <= PW'(e0_s1[k]) * PW'(e0_s1[k]);
				prod_s2[1][k] <= PW'(e0_s1[k]) * PW'(e1_s1[k]);
				prod_s2[2][k] <= PW'(e1_s1[k]) * PW'(e1_s1[k]);
				prod_s2[3][k] <= PW'(p_s1[k]) * PW'(e0_s1[k]);
				prod_s2[4][k] <= PW'(p_s1[k]) * PW'(e1_s1[k]);
			end
			for (int j = 0; j < 5; j++) begin
				dot_s3[j] <= SW'(prod_s2[j][0]) + SW'(prod_s2[j][1]) + SW'(prod_s2[j][2]);
			end
			// Wide products are split into halves; the low half is unsigned.
			for (int m = 0; m < NPROD; m++) begin
				hh_s4[m] <= PPW'($signed(dot_s3[PA[m]][SW-1:HB]))
					* PPW'($signed(dot_s3[PB[m]][SW-1:HB]));
				hl_s4[m] <= PPW'($signed(dot_s3[PA[m]][SW-1:HB]))
					* PPW'($signed({1'b0, dot_s3[PB[m]][HB-1:0]}));
				lh_s4[m] <= PPW'($signed({1'b0, dot_s3[PA[m]][HB-1:0]}))
					* PPW'($signed(dot_s3[PB[m]][SW-1:HB]));
				ll_s4[m] <= PPW'($signed({1'b0, dot_s3[PA[m]][HB-1:0]}))
					* PPW'($signed({1'b0, dot_s3[PB[m]][HB-1:0]}));
			end
			for (int m = 0; m < NPROD; m++) begin
				t_s5[m] <= (GW'(hh_s4[m]) <<< (2 * HB))
					+ ((GW'(hl_s4[m]) + GW'(lh_s4[m])) <<< HB) + GW'(ll_s4[m]);
			end
			den_s6 <= NW'(t_s5[0]) - NW'(t_s5[1]);
			nb_s6 <= NW'(t_s5[2]) - NW'(t_s5[3]);
			nc_s6 <= NW'(t_s5[4]) - NW'(t_s5[5]);
			den_s7 <= den_s6;
			nb_s7 <= nb_s6;
			nc_s7 <= nc_s6;
			na_s7 <= den_s6 - nb_s6 - nc_s6;
			deg_s7 <= (den_s6 == '0);
		end
	end

endmodule

[sv/tbw_queue.sv]
// ----------------------------------------------------------------------------
// tbw_queue: short register queue between the front and back parts
// Holds numerator sets so that either side can stall on its own.
// ----------------------------------------------------------------------------
module tbw_queue #(
	parameter int W = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [W-1:0] push_data,
	input  logic pop,
	output logic [W-1:0] pop_data,
	output tbw_pkg::tbw_qstat_t qstat
);
	localparam int AW = tbw_pkg::QUEUE_AW;

	logic [W-1:0] ent_q [tbw_pkg::QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0] cnt_q;

	assign qstat.full = (cnt_q == (AW + 1)'(tbw_pkg::QUEUE_DEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign pop_data = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[sv/tbw_back.sv]
// ----------------------------------------------------------------------------
// tbw_back: pipelined fixed-point division of the three weights
// Saturation check, one quotient bit per stage, then the output register.
// ----------------------------------------------------------------------------
module tbw_back #(
	parameter int NW = 75,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  tbw_pkg::tbw_qstat_t qstat,
	input  logic [4*NW:0] pop_data,
	output logic pop,
	tbw_out_if.source result
);
	localparam int QB = tbw_pkg::QUOT_BITS;
	localparam int CW = NW + QB;
	localparam int WW = tbw_pkg::WEIGHT_W;

	logic en;
	logic out_v_q;

	logic signed [NW-1:0] num [3];
	logic [NW-1:0] den_u;
	logic deg_in;
	logic [NW-1:0] mag [3];
	logic [CW-1:0] xl [3];
	logic [CW-1:0] dl;

	// Stage 0 is the saturation check; stage k+1 has settled quotient bit QB-1-k.
	logic vld_sn [QB+1];
	logic deg_sn [QB+1];
	logic [NW-1:0] den_sn [QB+1];
	logic [NW-1:0] rem_sn [QB+1][3];
	logic [QB-1:0] quo_sn [QB+1][3];
	logic [QB-1:0] xlo_sn [QB+1][3];
	logic neg_sn [QB+1][3];
	logic sat_sn [QB+1][3];

	logic [NW:0] trial [QB][3];
	logic take [QB][3];
	logic signed [WW-1:0] wt [3];

	assign en = !out_v_q || result.ready;
	assign pop = en && !qstat.empty;
	assign result.valid = out_v_q;

	always_comb begin
		deg_in = pop_data[4*NW];
		den_u = pop_data[4*NW-1:3*NW];
		num[0] = $signed(pop_data[3*NW-1:2*NW]);
		num[1] = $signed(pop_data[2*NW-1:NW]);
		num[2] = $signed(pop_data[NW-1:0]);
		dl = CW'(den_u) << QB;
		for (int l = 0; l < 3; l++) begin
			mag[l] = num[l][NW-1] ? NW'(-num[l]) : NW'(num[l]);
			xl[l] = CW'(mag[l]) << FRAC_BITS;
		end
	end

	always_comb begin
		for (int k = 0; k < QB; k++) begin
			for (int l = 0; l < 3; l++) begin
				trial[k][l] = {rem_sn[k][l], xlo_sn[k][l][QB-1-k]};
				take[k][l] = (trial[k][l] >= {1'b0, den_sn[k]});
			end
		end
	end

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (deg_sn[QB]) begin
				wt[l] = tbw_pkg::WEIGHT_ZERO;
			end else if (sat_sn[QB][l]) begin
				wt[l] = neg_sn[QB][l] ? tbw_pkg::WEIGHT_MIN : tbw_pkg::WEIGHT_MAX;
			end else if (neg_sn[QB][l]) begin
				wt[l] = -$signed({1'b0, quo_sn[QB][l]});
			end else begin
				wt[l] = $signed({1'b0, quo_sn[QB][l]});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			for (int k = 0; k <= QB; k++) begin
				vld_sn[k] <= 1'b0;
			end
		end else if (en) begin
			vld_sn[0] <= pop;
			for (int k = 0; k < QB; k++) begin
				vld_sn[k+1] <= vld_sn[k];
			end
			out_v_q <= vld_sn[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			deg_sn[0] <= deg_in;
			den_sn[0] <= den_u;
			for (int l = 0; l < 3; l++) begin
				neg_sn[0][l] <= num[l][NW-1];
				sat_sn[0][l] <= (xl[l] >= dl);
				rem_sn[0][l] <= NW'(xl[l] >> QB);
				xlo_sn[0][l] <= xl[l][QB-1:0];
				quo_sn[0][l] <= '0;
			end
			for (int k = 0; k < QB; k++) begin
				deg_sn[k+1] <= deg_sn[k];
				den_sn[k+1] <= den_sn[k];
				for (int l = 0; l < 3; l++) begin
					neg_sn[k+1][l] <= neg_sn[k][l];
					sat_sn[k+1][l] <= sat_sn[k][l];
					xlo_sn[k+1][l] <= xlo_sn[k][l];
					quo_sn[k+1][l] <= {quo_sn[k][l][QB-2:0], take[k][l]};
					rem_sn[k+1][l] <= take[k][l] ? NW'(trial[k][l] - {1'b0, den_sn[k]})
						: NW'(trial[k][l]);
				end
			end
			result.weight_a <= wt[0];
			result.weight_b <= wt[1];
			result.weight_c <= wt[2];
			result.degenerate <= deg_sn[QB];
		end
	end

endmodule

[sv/triangle_barycentric_weights_unit.sv]
// ----------------------------------------------------------------------------
// triangle_barycentric_weights_unit: barycentric weights of a point in 3D
// Exact integer Gram determinant and numerators, then pipelined division
// into signed Q16.16 weights, truncated toward zero and saturated.
// ----------------------------------------------------------------------------
//
//  channel  | role   | beat contents
//  ---------+--------+-----------------------------------------------------
//  query    | sink   | query point and vertices A, B, C, COORD_BITS each
//  result   | source | weight_a, weight_b, weight_c (32-bit), degenerate
//
// One beat is taken and one beat is delivered per clock cycle while result
// is ready. A beat passes the front pipeline, the queue and the division
// pipeline in turn; the division stage count is set by the thirty-one
// quotient bits, one per stage.
// Reset clears only valid bits, queue pointers and count; no clearing pass.
// A stall on result holds the back part; the front keeps taking beats until
// the four-entry queue and the last front stage are both full, and only then
// drops query.ready.
//
module triangle_barycentric_weights_unit #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	tbw_in_if.sink query,
	tbw_out_if.source result
);
	// Widths of the exact arithmetic: coordinate differences, dot products,
	// their products, and finally numerators with headroom for the sum of
	// three terms that forms the first weight.
	localparam int DOT_W = 2 * (COORD_BITS + 1) + 2;
	localparam int NUM_W = 2 * DOT_W + 3;
	localparam int QW = 4 * NUM_W + 1;

	logic push;
	logic pop;
	logic [QW-1:0] push_data;
	logic [QW-1:0] pop_data;
	tbw_pkg::tbw_qstat_t qstat;

	// The front part forms edge vectors, the five dot products, the Gram
	// determinant and the three numerators, and flags a zero determinant.
	tbw_front #(
		.COORD_BITS(COORD_BITS),
		.NW(NUM_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.query(query),
		.qstat(qstat),
		.push(push),
		.push_data(push_data)
	);

	// The queue decouples the two parts so that each can stall alone.
	tbw_queue #(
		.W(QW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(pop),
		.pop_data(pop_data),
		.qstat(qstat)
	);

	// The back part divides each numerator, scaled by the fraction bits,
	// by the determinant and drives the registered result beat.
	tbw_back #(
		.NW(NUM_W),
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.qstat(qstat),
		.pop_data(pop_data),
		.pop(pop),
		.result(result)
	);

`ifndef SYNTHESIS
	// A degenerate triangle must leave all three weights at zero.
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.degenerate |->
			result.weight_a == tbw_pkg::WEIGHT_ZERO
			&& result.weight_b == tbw_pkg::WEIGHT_ZERO
			&& result.weight_c == tbw_pkg::WEIGHT_ZERO)
		else $error("degenerate result with nonzero weight");

	// The front never pushes into a full queue, the back never pops an empty one.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("queue underflow");

	// A query beat is refused only while the queue is full.
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!query.ready |-> qstat.full)
		else $error("query refused while queue has room");
`endif

endmodule
